// File: hdl/scmd_pkg.sv
// Package for the servo click mode decoder: types, codes and reset values.
// Used by the channel interfaces and by every module of the block.
`timescale 1ns / 1ps

package scmd_pkg;

  // Field widths.
  localparam int unsigned WidthW   = 16;
  localparam int unsigned TicksW   = 8;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_PULSE_MIN     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PULSE_MAX     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LOW_THRESH    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HIGH_THRESH   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CLICK_TIMEOUT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STARTUP_DELAY = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [WidthW-1:0] RST_PULSE_MIN     = 16'd600;
  localparam logic [WidthW-1:0] RST_PULSE_MAX     = 16'd2500;
  localparam logic [WidthW-1:0] RST_LOW_THRESH    = 16'd1375;
  localparam logic [WidthW-1:0] RST_HIGH_THRESH   = 16'd1625;
  localparam logic [TicksW-1:0] RST_CLICK_TIMEOUT = 8'd12;
  localparam logic [TicksW-1:0] RST_STARTUP_DELAY = 8'd90;

  // Click count values with a meaning of their own.
  localparam logic [CountW-1:0] CLICKS_IN     = 8'd1;
  localparam logic [CountW-1:0] CLICKS_OUT    = 8'd2;
  localparam logic [CountW-1:0] CLICKS_TOGGLE = 8'd5;
  localparam logic [CountW-1:0] CLICKS_POISON = 8'd99;

  // Operation codes of an input word.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PULSE = 1'b1;

  // Mode codes as they appear on the result channel.
  localparam logic [ModeW-1:0] MODE_CODE_UNINIT = 3'd0;
  localparam logic [ModeW-1:0] MODE_CODE_OFF    = 3'd1;
  localparam logic [ModeW-1:0] MODE_CODE_IDLE   = 3'd2;
  localparam logic [ModeW-1:0] MODE_CODE_IN     = 3'd3;
  localparam logic [ModeW-1:0] MODE_CODE_OUT    = 3'd4;

  // Mode state machine, one-hot.
  typedef enum logic [4:0] {
    MODE_UNINIT = 5'b00001,
    MODE_OFF    = 5'b00010,
    MODE_IDLE   = 5'b00100,
    MODE_IN     = 5'b01000,
    MODE_OUT    = 5'b10000
  } mode_e;

  // Configuration register set.
  typedef struct packed {
    logic [WidthW-1:0] pulse_min_us;
    logic [WidthW-1:0] pulse_max_us;
    logic [WidthW-1:0] low_threshold_us;
    logic [WidthW-1:0] high_threshold_us;
    logic [TicksW-1:0] click_timeout_ticks;
    logic [TicksW-1:0] startup_delay_ticks;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             pulse_accepted;
    logic             toggled;
  } res_t;

  // Maps the one-hot mode state onto its output code.
  function automatic logic [ModeW-1:0] mode_code(mode_e m);
    logic [ModeW-1:0] c;
    case (m)
      MODE_OFF:  c = MODE_CODE_OFF;
      MODE_IDLE: c = MODE_CODE_IDLE;
      MODE_IN:   c = MODE_CODE_IN;
      MODE_OUT:  c = MODE_CODE_OUT;
      default:   c = MODE_CODE_UNINIT;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/scmd_if.sv
// Channel interfaces of the servo click mode decoder: input, result and
// configuration. Depends on scmd_pkg for the field widths.
`timescale 1ns / 1ps

// Input words: a timer tick or a measured pulse.
interface scmd_in_if;
  import scmd_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [WidthW-1:0] pulse_width_us;

  modport source (output valid, output op, output pulse_width_us, input ready);
  modport sink   (input valid, input op, input pulse_width_us, output ready);
endinterface

// Result words: mode and pulse flags.
interface scmd_out_if;
  import scmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic             pulse_accepted;
  logic             toggled;

  modport source (output valid, output mode, output pulse_accepted, output toggled,
                  input ready);
  modport sink   (input valid, input mode, input pulse_accepted, input toggled,
                  output ready);
endinterface

// Configuration writes: register index and data.
interface scmd_cfg_if;
  import scmd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/scmd_cfg_regs.sv
// Configuration register file of the servo click mode decoder.
// Depends on scmd_pkg and the configuration channel interface.
`timescale 1ns / 1ps

module scmd_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  scmd_cfg_if.sink      cfg_if,
  output scmd_pkg::cfg_t cfg_o
);
  import scmd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_if.ready = 1'b1;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_PULSE_MIN:     cfg_d.pulse_min_us        = cfg_if.data;
        REG_PULSE_MAX:     cfg_d.pulse_max_us        = cfg_if.data;
        REG_LOW_THRESH:    cfg_d.low_threshold_us    = cfg_if.data;
        REG_HIGH_THRESH:   cfg_d.high_threshold_us   = cfg_if.data;
        REG_CLICK_TIMEOUT: cfg_d.click_timeout_ticks = cfg_if.data[TicksW-1:0];
        REG_STARTUP_DELAY: cfg_d.startup_delay_ticks = cfg_if.data[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min_us        <= RST_PULSE_MIN;
      cfg_q.pulse_max_us        <= RST_PULSE_MAX;
      cfg_q.low_threshold_us    <= RST_LOW_THRESH;
      cfg_q.high_threshold_us   <= RST_HIGH_THRESH;
      cfg_q.click_timeout_ticks <= RST_CLICK_TIMEOUT;
      cfg_q.startup_delay_ticks <= RST_STARTUP_DELAY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/scmd_core.sv
// Decoder state and the per-word update logic of the servo click mode
// decoder. Depends on scmd_pkg.
`timescale 1ns / 1ps

module scmd_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          op_i,
  input  logic [scmd_pkg::WidthW-1:0]   pulse_width_us_i,
  input  scmd_pkg::cfg_t                cfg_i,
  output scmd_pkg::res_t                res_o
);
  import scmd_pkg::*;

  mode_e             mode_q, mode_d;
  logic              level_q, level_d;
  logic [CountW-1:0] count_q, count_d;
  logic [TicksW-1:0] timer_q, timer_d;

  logic accepted, toggled, level_new, in_range, waiting;

  // Pulse classification.
  assign waiting  = (mode_q == MODE_UNINIT) && (timer_q != '0);
  assign in_range = (pulse_width_us_i >= cfg_i.pulse_min_us) &&
                    (pulse_width_us_i <= cfg_i.pulse_max_us);

  // Hysteresis: the threshold in use depends on the current level.
  assign level_new = level_q ? (pulse_width_us_i >= cfg_i.low_threshold_us)
                             : (pulse_width_us_i >  cfg_i.high_threshold_us);

  // Next state for one word.
  always_comb begin
    mode_d   = mode_q;
    level_d  = level_q;
    count_d  = count_q;
    timer_d  = timer_q;
    accepted = 1'b0;
    toggled  = 1'b0;
    if (op_i == OP_TICK) begin
      if (timer_q != '0) begin
        timer_d = timer_q - 1'b1;
      end
    end else if (!waiting) begin
      if (!in_range) begin
        if (mode_q == MODE_UNINIT) begin
          timer_d = cfg_i.startup_delay_ticks;
        end
      end else begin
        accepted = 1'b1;
        if (mode_q == MODE_UNINIT) begin
          // First valid pulse sets the reference level and leaves the uninit mode; it counts no click.
          level_d = level_new;
          mode_d  = MODE_OFF;
        end else if (level_new != level_q) begin
          level_d = level_new;
          toggled = 1'b1;
          count_d = count_q + 1'b1;
          timer_d = cfg_i.click_timeout_ticks;
          if (mode_q == MODE_IN || mode_q == MODE_OUT) begin
            mode_d  = MODE_IDLE;
            count_d = CLICKS_POISON;
          end
        end
        // Evaluate the clicks on an accepted pulse once the timeout has run out.
        if (count_d != '0 && timer_d == '0) begin
          case (count_d)
            CLICKS_IN: begin
              if (mode_d == MODE_IDLE) mode_d = MODE_IN;
            end
            CLICKS_OUT: begin
              if (mode_d == MODE_IDLE) mode_d = MODE_OUT;
            end
            CLICKS_TOGGLE: begin
              mode_d = (mode_d == MODE_IDLE) ? MODE_OFF : MODE_IDLE;
            end
            default: ;
          endcase
          count_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_UNINIT;
      level_q <= 1'b0;
      count_q <= '0;
      timer_q <= RST_STARTUP_DELAY;
    end else if (step_i) begin
      mode_q  <= mode_d;
      level_q <= level_d;
      count_q <= count_d;
      timer_q <= timer_d;
    end
  end

  assign res_o.mode           = mode_code(mode_d);
  assign res_o.pulse_accepted = accepted;
  assign res_o.toggled        = toggled;

endmodule

// File: hdl/servo_click_mode_decoder_top.sv
// Top level of the servo click mode decoder: input register, decoder core,
// result register. Depends on scmd_pkg, scmd_if, scmd_cfg_regs, scmd_core.
//
//   Channel  Dir  Payload                              Words
//   in_if    in   op, pulse_width_us                   tick or pulse
//   out_if   out  mode, pulse_accepted, toggled        one per input word
//   cfg_if   in   index, data                          register write
//
// An accepted input word passes through the input register and the core into
// the result register; one word is taken every cycle while the result is not
// stalled. Reset loads the register reset values and the startup delay into
// the click timer. A stalled result holds both registers; the input side
// keeps taking words while the result register can move on.
`timescale 1ns / 1ps

module servo_click_mode_decoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  scmd_in_if.sink   in_if,
  scmd_out_if.source out_if,
  scmd_cfg_if.sink  cfg_if
);
  import scmd_pkg::*;

  cfg_t              cfg;
  res_t              res;
  logic              in_valid_q;
  logic              in_op_q;
  logic [WidthW-1:0] in_width_q;
  logic              out_valid_q;
  res_t              out_q;
  logic              out_free, step;

  scmd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  // Handshake: the input register moves into the result register.
  assign out_free    = !out_valid_q || out_if.ready;
  assign step        = in_valid_q && out_free;
  assign in_if.ready = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_op_q    <= in_if.op;
      in_width_q <= in_if.pulse_width_us;
    end
  end

  scmd_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .op_i             (in_op_q),
    .pulse_width_us_i (in_width_q),
    .cfg_i            (cfg),
    .res_o            (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.mode           = out_q.mode;
  assign out_if.pulse_accepted = out_q.pulse_accepted;
  assign out_if.toggled        = out_q.toggled;

endmodule
